// File: rtl/core/acu_pkg.sv
package acu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] CMD_LOAD = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_REM  = 3'd5;
    localparam logic [2:0] CMD_NOP  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take_item;
        logic do_simple;
        logic mul_init;
        logic mul_step;
        logic mul_end;
        logic div_init;
        logic div_step;
        logic div_fix;
        logic set_err;
        logic out_load;
    } dp_ctrl_t;

    typedef struct packed {
        logic is_mul;
        logic is_divrem;
        logic b_zero;
        logic last;
    } dp_stat_t;

endpackage

// File: rtl/core/acu_dp.sv
module acu_dp
    import acu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    output dp_stat_t           stat,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] operand,
    input  logic               last,
    output logic signed [31:0] value,
    output logic               div_error
);

    logic [2:0]                   cmd_reg;
    logic                         last_reg;
    logic signed [DATA_WIDTH-1:0] b_reg;
    logic signed [DATA_WIDTH-1:0] acc_reg;
    logic signed [DATA_WIDTH-1:0] acc_next;
    logic                         err_reg;
    logic                         err_next;
    logic [DATA_WIDTH-1:0]        wa_reg;
    logic [DATA_WIDTH-1:0]        wq_reg;
    logic [DATA_WIDTH-1:0]        wd_reg;
    logic signed [31:0]           value_reg;
    logic                         div_error_reg;

    logic [DATA_WIDTH-1:0]        mag_a;
    logic [DATA_WIDTH-1:0]        mag_b;
    logic [DATA_WIDTH-1:0]        mul_sum;
    logic [DATA_WIDTH-1:0]        trial;
    logic [DATA_WIDTH-1:0]        diff;
    logic                         ge;
    logic [DATA_WIDTH-1:0]        res_mag;
    logic                         res_neg;
    logic [DATA_WIDTH-1:0]        fix_val;

    assign mag_a   = acc_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-acc_reg) : acc_reg;
    assign mag_b   = b_reg[DATA_WIDTH-1] ? DATA_WIDTH'(-b_reg) : b_reg;
    assign mul_sum = wa_reg + (wq_reg[0] ? wd_reg : '0);

    // restoring divide: shift next dividend bit into the partial remainder
    assign trial = {wa_reg[DATA_WIDTH-2:0], wq_reg[DATA_WIDTH-1]};
    assign ge    = (trial >= wd_reg);
    assign diff  = trial - wd_reg;

    // quotient sign is the xor of signs, remainder follows the dividend
    assign res_mag = (cmd_reg == CMD_DIV) ? wq_reg : wa_reg;
    assign res_neg = (cmd_reg == CMD_DIV) ? (acc_reg[DATA_WIDTH-1] ^ b_reg[DATA_WIDTH-1])
                                          : acc_reg[DATA_WIDTH-1];
    assign fix_val = res_neg ? DATA_WIDTH'(-res_mag) : res_mag;

    always_comb
    begin
        acc_next = acc_reg;
        err_next = err_reg;
        if (ctrl.do_simple)
        begin
            case (cmd_reg)
                CMD_LOAD:
                begin
                    acc_next = b_reg;
                    err_next = 1'b0;
                end
                CMD_ADD: acc_next = acc_reg + b_reg;
                CMD_SUB: acc_next = acc_reg - b_reg;
                default: acc_next = acc_reg;
            endcase
        end
        if (ctrl.set_err)
        begin
            err_next = 1'b1;
        end
        if (ctrl.mul_end)
        begin
            acc_next = mul_sum;
        end
        if (ctrl.div_fix)
        begin
            acc_next = fix_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take_item)
        begin
            cmd_reg  <= cmd;
            last_reg <= last;
            b_reg    <= DATA_WIDTH'(operand);
        end
        if (ctrl.mul_init)
        begin
            wa_reg <= '0;
            wq_reg <= b_reg;
            wd_reg <= acc_reg;
        end
        else if (ctrl.mul_step)
        begin
            wa_reg <= mul_sum;
            wq_reg <= wq_reg >> 1;
            wd_reg <= wd_reg << 1;
        end
        else if (ctrl.div_init)
        begin
            wa_reg <= '0;
            wq_reg <= mag_a;
            wd_reg <= mag_b;
        end
        else if (ctrl.div_step)
        begin
            wa_reg <= ge ? diff : trial;
            wq_reg <= {wq_reg[DATA_WIDTH-2:0], ge};
        end
        if (ctrl.out_load)
        begin
            value_reg     <= 32'(acc_reg);
            div_error_reg <= err_reg;
        end
    end

    always_comb
    begin
        stat.is_mul    = (cmd_reg == CMD_MUL);
        stat.is_divrem = cmd_reg inside {CMD_DIV, CMD_REM};
        stat.b_zero    = (b_reg == '0);
        stat.last      = last_reg;
    end

    assign value     = value_reg;
    assign div_error = div_error_reg;

endmodule

// File: rtl/core/acu_ctrl.sv
module acu_ctrl
    import acu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            cnt_last;
    logic            slot_free;

    assign cnt_last  = (cnt_reg == CW'(DATA_WIDTH - 1));
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_mul)
                begin
                    state_next = ST_MUL;
                end
                else if (stat.is_divrem && !stat.b_zero)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                if (cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (cnt_last)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // a last item holds until the output register can take the result
                if (!stat.last || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.take_item = in_valid;
            end
            ST_EXEC:
            begin
                if (stat.is_mul)
                begin
                    ctrl.mul_init = 1'b1;
                end
                else if (stat.is_divrem)
                begin
                    ctrl.set_err  = stat.b_zero;
                    ctrl.div_init = !stat.b_zero;
                end
                else
                begin
                    ctrl.do_simple = 1'b1;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
                ctrl.mul_end  = cnt_last;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
            end
            ST_FIX:
            begin
                ctrl.div_fix = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.out_load = stat.last && slot_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.mul_init || ctrl.div_init)
        begin
            cnt_next = '0;
        end
        else if (ctrl.mul_step || ctrl.div_step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start execution");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV) |-> (cnt_reg <= CW'(DATA_WIDTH - 1)))
        else $error("iteration counter out of range");

    a_div_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV || state_reg == ST_FIX))
        else $error("divide loop left without sign fix-up");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !ctrl.out_load)
        else $error("pending result overwritten");

endmodule

// File: rtl/core/accumulator_calculator_unit.sv
// channel  | signals                        | item accepted when
// ---------+--------------------------------+----------------------------
// input    | in_valid, in_stall, cmd,       | in_valid && !in_stall
//          | operand, last                  |
// output   | out_valid, out_stall, value,   | out_valid && !out_stall
//          | div_error                      |
//
// one item at a time: load, add, sub, no-op and divide by zero pass through the idle,
// exec and done states, mul through idle, exec, the shift-add loop and done, div and rem
// through idle, exec, the restoring divide loop, the sign fix-up and done
// rst_n clears the accumulator, the error flag, the controller and out_valid
// a result waits in the output register; the next item is taken meanwhile,
// and only a further last item stalls until that result is taken
module accumulator_calculator_unit
    import acu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] operand,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    output logic               div_error
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    acu_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    acu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cmd       (cmd),
        .operand   (operand),
        .last      (last),
        .value     (value),
        .div_error (div_error)
    );

endmodule
